>>> rtl/btk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types and constants for the bounded top-k smallest heap.
// ----------------------------------------------------------------------------
package btk_pkg;

    localparam int VALUE_W  = 32;
    localparam int KEEP_W   = 11;
    localparam int STATUS_W = 2;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd1024;

    // operation codes
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_POP   = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_UP,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_L,
        S_DN_R,
        S_FIN,
        S_DONE
    } btk_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] popped;
        logic [KEEP_W-1:0]         held;
    } btk_result_t;

endpackage
`default_nettype wire

>>> rtl/btk_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btk_engine
// Heap store and sequencer: insert with sift-up, root replace and pop with
// sift-down, on a registered-read RAM with a separate read port and write port.
// ----------------------------------------------------------------------------
module btk_engine
    import btk_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        start_op,
    input  wire logic signed [VALUE_W-1:0]   start_value,
    input  wire logic [$clog2(CAPACITY+1)-1:0] limit,
    input  wire logic                        out_ready,
    output logic                             idle,
    output logic                             result_valid,
    output btk_result_t                      result
);

    localparam int CW = $clog2(CAPACITY + 1);   // count / slot width
    localparam int AW = $clog2(CAPACITY);       // RAM address width
    localparam int PW = CW + 1;                 // child slot width
    localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;

    btk_state_t state_reg, state_next;

    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             pos_reg, pos_next;     // 1-based hole slot
    logic signed [VALUE_W-1:0] val_reg, val_next;     // value being placed
    logic signed [VALUE_W-1:0] lc_reg, lc_next;       // left child value
    logic signed [VALUE_W-1:0] popped_reg, popped_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    // heap RAM, slot s lives at address s-1
    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      rd_en, wr_en;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic signed [VALUE_W-1:0] wr_data;

    logic [PW-1:0]             child_l, child_r, count_p;
    logic [PW-1:0]             pick;
    logic [PW:0]               grand;
    logic signed [VALUE_W-1:0] pick_val;
    logic                      do_move;
    logic [LW-1:0]             count_ext;

    function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] s);
        logic [CW-1:0] t;
        t = s - CW'(1);
        return t[AW-1:0];
    endfunction

    assign child_l   = {pos_reg, 1'b0};
    assign child_r   = {pos_reg, 1'b1};
    assign count_p   = PW'(count_reg);
    assign count_ext = LW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        lc_reg     <= lc_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    // right-child step: pick the larger child if it beats the held value
    always_comb
    begin
        pick     = child_l;
        pick_val = lc_reg;
        do_move  = 1'b0;
        if (rd_data_reg > ((lc_reg > val_reg) ? lc_reg : val_reg))
        begin
            pick     = child_r;
            pick_val = rd_data_reg;
            do_move  = 1'b1;
        end
        else if (lc_reg > val_reg)
        begin
            do_move = 1'b1;
        end
        grand = {pick, 1'b0};
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        lc_next     = lc_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = slot_addr(pos_reg);
        wr_data     = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next    = start_value;
                    popped_next = '0;
                    if (start_op == OP_OFFER)
                    begin
                        if (count_reg < limit)
                        begin
                            status_next = ST_ACCEPTED;
                            count_next  = count_reg + CW'(1);
                            pos_next    = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = start_value;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_addr((count_reg + CW'(1)) >> 1);
                                state_next = S_UP;
                            end
                        end
                        else if (count_reg == limit && count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_ROOT;
                        end
                        else
                        begin
                            status_next = ST_REJECTED;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_POP_ROOT;
                        end
                    end
                end
            end

            S_UP:
            begin
                if (rd_data_reg < val_reg)
                begin
                    // parent moves down into the hole
                    wr_en    = 1'b1;
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg >> 1;
                    if ((pos_reg >> 1) == CW'(1))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = slot_addr(pos_reg >> 2);
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_ROOT:
            begin
                if (rd_data_reg > val_reg)
                begin
                    status_next = ST_ACCEPTED;
                    pos_next    = CW'(1);
                    if (count_reg >= CW'(2))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(1);
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    status_next = ST_REJECTED;
                    state_next  = S_DONE;
                end
            end

            S_POP_ROOT:
            begin
                popped_next = rd_data_reg;
                status_next = ST_POPPED;
                count_next  = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_addr(count_reg);
                    state_next = S_POP_LAST;
                end
            end

            S_POP_LAST:
            begin
                // last entry refills the root; count already reduced
                val_next = rd_data_reg;
                pos_next = CW'(1);
                if (count_reg >= CW'(2))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(1);
                    state_next = S_DN_L;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = rd_data_reg;
                    state_next = S_DONE;
                end
            end

            S_DN_L:
            begin
                lc_next = rd_data_reg;
                if (child_r <= count_p)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_addr(child_r[CW-1:0]);
                    state_next = S_DN_R;
                end
                else if (rd_data_reg > val_reg)
                begin
                    // only child moves up; it has no children of its own
                    wr_en      = 1'b1;
                    wr_data    = rd_data_reg;
                    pos_next   = child_l[CW-1:0];
                    state_next = S_FIN;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DN_R:
            begin
                wr_en = 1'b1;
                if (do_move)
                begin
                    wr_data  = pick_val;
                    pos_next = pick[CW-1:0];
                    if (grand <= {1'b0, count_p})
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = slot_addr(grand[CW-1:0]);
                        state_next = S_DN_L;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FIN:
            begin
                wr_en      = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle          = (state_reg == S_IDLE);
    assign result_valid  = (state_reg == S_DONE);
    assign result.status = status_reg;
    assign result.popped = popped_reg;
    assign result.held   = count_ext[KEEP_W-1:0];

endmodule
`default_nettype wire

>>> rtl/bounded_top_k_smallest_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_top_k_smallest_heap
// Keeps the k smallest signed 32-bit values in a binary max-heap held in a
// single-port-read RAM; offers insert, replace the root or are rejected; pops return the max.
// ----------------------------------------------------------------------------
//
//  channel   direction  contents
//  s_axis    in         tuser[0] operation (0 offer, 1 pop), tdata[31:0] value
//  m_axis    out        tuser[1:0] status, tdata[31:0] popped value,
//                       tdata[42:32] held count, tdata[47:43] zero
//  cfg       in         cfg_we / cfg_wdata[10:0] keep count (k)
//
//  One transaction at a time. Each one steps through the heap RAM, which has a
//  registered read: an empty pop, or a reject without a root read, needs no
//  RAM read; a reject against the root reads the root; an insert writes an
//  empty heap directly, else climbs with one parent read per level; a root
//  replace descends with two child reads per level, and a pop also reads the last entry.
//  Reset clears the held count and sets k to 1024; RAM contents need no clear.
//  A finished result sits in the m_axis register; the next transaction is
//  taken meanwhile and only stalls at its own completion if m_axis is held.
// ----------------------------------------------------------------------------
module bounded_top_k_smallest_heap
    import btk_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
    input  wire logic                s_axis_tuser,   // [0] operation
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [47:0]              m_axis_tdata,   // [31:0] popped_value, [42:32] held_count
    output logic [STATUS_W-1:0]      m_axis_tuser,   // [1:0] status
    // configuration
    input  wire logic                cfg_we,
    input  wire logic [KEEP_W-1:0]   cfg_wdata       // keep_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;
    localparam logic [LW-1:0] CAP_EXT = LW'(CAPACITY);

    logic [KEEP_W-1:0] keep_count_reg;
    logic [LW-1:0]     keep_ext;
    logic [CW-1:0]     limit;

    logic              eng_idle;
    logic              eng_valid;
    logic              out_ready;
    btk_result_t       eng_result;

    logic              m_valid_reg, m_valid_next;
    btk_result_t       m_data_reg;

    // keep count register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_RESET;
        end
        else if (cfg_we)
        begin
            keep_count_reg <= cfg_wdata;
        end
    end

    // effective limit: smaller of k and the heap capacity
    assign keep_ext = LW'(keep_count_reg);
    assign limit    = (keep_ext > CAP_EXT) ? CAP_EXT[CW-1:0] : keep_ext[CW-1:0];

    assign s_axis_tready = eng_idle;

    // engine result moves into the output register when that slot is free
    assign out_ready = !m_valid_reg || m_axis_tready;

    btk_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (s_axis_tvalid && eng_idle),
        .start_op     (s_axis_tuser),
        .start_value  ($signed(s_axis_tdata)),
        .limit        (limit),
        .out_ready    (out_ready),
        .idle         (eng_idle),
        .result_valid (eng_valid),
        .result       (eng_result)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (eng_valid && out_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && out_ready)
        begin
            m_data_reg <= eng_result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_data_reg.status;
    assign m_axis_tdata  = {5'b0, m_data_reg.held, m_data_reg.popped};

endmodule
`default_nettype wire
